### hw/rtl/grid_table_interpolator_2d_top_defines.svh
// assertion macros for the grid table interpolator
`ifndef GRID_TABLE_INTERPOLATOR_2D_TOP_DEFINES_SVH
`define GRID_TABLE_INTERPOLATOR_2D_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GTI_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define GTI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/gti_pkg.sv
// shared types and constants of the grid table interpolator
package gti_pkg;

    localparam int VAL_W  = 32;
    localparam int ACC_W  = 48;
    localparam int T_W    = 22;
    localparam int PROD_W = ACC_W + T_W;

    localparam logic [1:0] MODE_NEAREST   = 2'd0;
    localparam logic [1:0] MODE_BILINEAR  = 2'd1;
    localparam logic [1:0] MODE_BICUBIC   = 2'd2;
    localparam logic [1:0] MODE_CUBIC_ALT = 2'd3;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_X_ORIGIN = 3'd1;
    localparam logic [2:0] REG_Y_ORIGIN = 3'd2;
    localparam logic [2:0] REG_X_SCALE  = 3'd3;
    localparam logic [2:0] REG_Y_SCALE  = 3'd4;
    localparam logic [2:0] REG_ROWS     = 3'd5;
    localparam logic [2:0] REG_COLS     = 3'd6;

    localparam logic signed [T_W-1:0] T_MAX = T_W'(524288);
    localparam logic signed [PROD_W-1:0] ROUND_Q16 = PROD_W'(32768);
    localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-32){1'b0}}, 32'h7fff_ffff};
    localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-32){1'b1}}, 32'h8000_0000};

    typedef enum logic [4:0] {
        DP_NOP,
        DP_WRITE,
        DP_LOAD,
        DP_MX_LO,
        DP_MX_HI,
        DP_MY_LO,
        DP_MY_HI,
        DP_MY_ADD,
        DP_INDEX,
        DP_READ,
        DP_BL_A,
        DP_BL_B,
        DP_BL_C,
        DP_CR_INIT,
        DP_MUL,
        DP_ACC,
        DP_CR_ROW,
        DP_FIN
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MX_LO,
        ST_MX_HI,
        ST_MY_LO,
        ST_MY_HI,
        ST_MY_ADD,
        ST_INDEX,
        ST_READ,
        ST_BL_A,
        ST_BL_B,
        ST_BL_C,
        ST_CR_INIT,
        ST_MUL,
        ST_ACC,
        ST_CR_ROW,
        ST_FIN
    } state_t;

    typedef struct packed {
        dp_op_t     op;
        logic [3:0] rd_idx;
        logic       t_fy;
        logic       src_row;
    } cmd_t;

    typedef struct packed {
        logic out_full;
    } stat_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] x_origin;
        logic [31:0] y_origin;
        logic [31:0] x_scale;
        logic [31:0] y_scale;
        logic [6:0]  rows_used;
        logic [6:0]  cols_used;
    } cfg_t;

endpackage

### hw/rtl/gti_ctrl.sv
// sequencer for table writes and interpolation queries
module gti_ctrl
    import gti_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       kind,
    input  logic       out_ready,
    input  logic [1:0] mode,
    input  stat_t      stat,
    output logic       in_ready,
    output cmd_t       cmd
);

    state_t     state_reg, state_next;
    logic [3:0] rd_cnt_reg, rd_cnt_next;
    logic [1:0] step_reg, step_next;
    logic [2:0] part_reg, part_next;
    logic       is_near;
    logic       is_bil;
    logic       rd_last;

    assign is_near = (mode == MODE_NEAREST);
    assign is_bil  = (mode == MODE_BILINEAR);

    always_comb
    begin
        if (is_near)
        begin
            rd_last = (rd_cnt_reg == 4'd0);
        end
        else if (is_bil)
        begin
            rd_last = (rd_cnt_reg == 4'd3);
        end
        else
        begin
            rd_last = (rd_cnt_reg == 4'd15);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rd_cnt_reg <= '0;
            step_reg   <= '0;
            part_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_cnt_reg <= rd_cnt_next;
            step_reg   <= step_next;
            part_reg   <= part_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        rd_cnt_next  = rd_cnt_reg;
        step_next    = step_reg;
        part_next    = part_reg;
        in_ready     = 1'b0;
        cmd.op       = DP_NOP;
        cmd.rd_idx   = rd_cnt_reg;
        cmd.t_fy     = is_bil ? (part_reg == 3'd2) : (part_reg == 3'd4);
        cmd.src_row  = (part_reg == 3'd4);
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (kind == KIND_QUERY)
                    begin
                        cmd.op     = DP_LOAD;
                        state_next = ST_MX_LO;
                    end
                    else
                    begin
                        cmd.op = DP_WRITE;
                    end
                end
            end
            ST_MX_LO:
            begin
                cmd.op     = DP_MX_LO;
                state_next = ST_MX_HI;
            end
            ST_MX_HI:
            begin
                cmd.op     = DP_MX_HI;
                state_next = ST_MY_LO;
            end
            ST_MY_LO:
            begin
                cmd.op     = DP_MY_LO;
                state_next = ST_MY_HI;
            end
            ST_MY_HI:
            begin
                cmd.op     = DP_MY_HI;
                state_next = ST_MY_ADD;
            end
            ST_MY_ADD:
            begin
                cmd.op     = DP_MY_ADD;
                state_next = ST_INDEX;
            end
            ST_INDEX:
            begin
                cmd.op      = DP_INDEX;
                rd_cnt_next = '0;
                step_next   = '0;
                part_next   = '0;
                state_next  = ST_READ;
            end
            ST_READ:
            begin
                cmd.op = DP_READ;
                if (rd_last)
                begin
                    rd_cnt_next = '0;
                    if (is_near)
                    begin
                        state_next = ST_FIN;
                    end
                    else if (is_bil)
                    begin
                        state_next = ST_BL_A;
                    end
                    else
                    begin
                        state_next = ST_CR_INIT;
                    end
                end
                else
                begin
                    rd_cnt_next = rd_cnt_reg + 4'd1;
                end
            end
            ST_BL_A:
            begin
                cmd.op     = DP_BL_A;
                state_next = ST_MUL;
            end
            ST_BL_B:
            begin
                cmd.op     = DP_BL_B;
                state_next = ST_MUL;
            end
            ST_BL_C:
            begin
                cmd.op     = DP_BL_C;
                state_next = ST_MUL;
            end
            ST_CR_INIT:
            begin
                cmd.op     = DP_CR_INIT;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.op     = DP_MUL;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.op = DP_ACC;
                if (is_bil)
                begin
                    part_next = part_reg + 3'd1;
                    case (part_reg)
                        3'd0:    state_next = ST_BL_B;
                        3'd1:    state_next = ST_BL_C;
                        default: state_next = ST_FIN;
                    endcase
                end
                else if (step_reg != 2'd2)
                begin
                    step_next  = step_reg + 2'd1;
                    state_next = ST_MUL;
                end
                else
                begin
                    step_next  = '0;
                    state_next = (part_reg == 3'd4) ? ST_FIN : ST_CR_ROW;
                end
            end
            ST_CR_ROW:
            begin
                cmd.op     = DP_CR_ROW;
                part_next  = part_reg + 3'd1;
                state_next = ST_CR_INIT;
            end
            ST_FIN:
            begin
                if (!stat.out_full || out_ready)
                begin
                    cmd.op     = DP_FIN;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/gti_datapath.sv
// table memory, coordinate mapping, shared multiplier and result register
module gti_datapath
    import gti_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    input  cfg_t               cfg,
    input  logic [11:0]        entry_index,
    input  logic signed [31:0] entry_value,
    input  logic signed [31:0] query_x,
    input  logic signed [31:0] query_y,
    input  logic               out_ready,
    output stat_t              stat,
    output logic               out_valid,
    output logic signed [31:0] result_value,
    output logic               saturated
);

    localparam int DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int AW      = $clog2(DEPTH);
    localparam int MAX_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int NW      = $clog2(MAX_DIM + 1);

    typedef struct packed {
        logic [NW-1:0]         idx;
        logic signed [T_W-1:0] frac;
    } axis_t;

    typedef struct packed {
        logic                    flag;
        logic signed [VAL_W-1:0] value;
    } sat_t;

    logic [VAL_W-1:0] grid_mem [DEPTH];

    logic signed [VAL_W-1:0]  samp_reg [16];
    logic signed [VAL_W-1:0]  rowv_reg [4];
    logic [31:0]              adx_reg, ady_reg;
    logic                     negx_reg, negy_reg;
    logic [63:0]              mx_reg, my_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [NW-1:0]            i0_reg, j0_reg;
    logic signed [T_W-1:0]    fx_reg, fy_reg;
    logic signed [ACC_W-1:0]  acc_reg, k0_reg, k1_reg, k2_reg, hold_reg;
    logic                     sat_flag_reg;
    logic                     out_valid_reg;
    logic signed [VAL_W-1:0]  result_reg;
    logic                     sat_out_reg;

    logic [NW-1:0]            rows_eff, cols_eff;
    logic signed [32:0]       dx, dy;
    logic signed [ACC_W-1:0]  mul_a;
    logic signed [T_W-1:0]    mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [ACC_W-1:0]  acc_half;
    axis_t                    ax_x, ax_y;
    logic                     near;
    logic                     cubic;
    logic signed [2:0]        off_i, off_j;
    logic [NW-1:0]            rd_i, rd_j;
    logic [2*NW-1:0]          row_base;
    logic [AW-1:0]            rd_addr;
    logic signed [ACC_W-1:0]  v0, v1, v2, v3;
    sat_t                     half_sat, acc_sat;

    function automatic axis_t axis_map(input logic [63:0] m, input logic neg,
                                       input logic [NW-1:0] n, input logic nearest);
        logic [64:0]   rsum;
        logic [36:0]   q;
        logic [NW-1:0] top_idx;
        logic [35:0]   ip;
        logic [51:0]   g;
        logic [51:0]   diff;
        logic [52:0]   gmag;
        axis_t         r;
        rsum   = '0;
        q      = '0;
        ip     = m[63:28];
        g      = m[63:12];
        diff   = '0;
        gmag   = '0;
        r.idx  = '0;
        r.frac = '0;
        if (nearest)
        begin
            top_idx = n - NW'(1);
            rsum    = {1'b0, m} + 65'(134217728);
            q       = rsum[64:28];
            if (!neg)
            begin
                r.idx = (q > 37'(top_idx)) ? top_idx : q[NW-1:0];
            end
        end
        else
        begin
            top_idx = n - NW'(2);
            if (neg)
            begin
                rsum   = {1'b0, m} + 65'(4095);
                gmag   = rsum[64:12];
                r.frac = (gmag > 53'(524288)) ? -T_MAX : -$signed(gmag[T_W-1:0]);
            end
            else if (ip > 36'(top_idx))
            begin
                r.idx  = top_idx;
                diff   = g - {36'(top_idx), 16'b0};
                r.frac = (diff > 52'(524288)) ? T_MAX : $signed(diff[T_W-1:0]);
            end
            else
            begin
                r.idx  = ip[NW-1:0];
                r.frac = T_W'(m[27:12]);
            end
        end
        return r;
    endfunction

    function automatic logic [NW-1:0] clamp_idx(input logic [NW-1:0] base,
                                                input logic signed [2:0] off,
                                                input logic [NW-1:0] n);
        logic signed [NW+1:0] s;
        logic [NW-1:0]        top_idx;
        top_idx = n - NW'(1);
        s       = $signed({2'b00, base}) + (NW+2)'(off);
        if (s < 0)
        begin
            return '0;
        end
        else if (s > $signed({2'b00, top_idx}))
        begin
            return top_idx;
        end
        return s[NW-1:0];
    endfunction

    function automatic sat_t sat32(input logic signed [ACC_W-1:0] v);
        sat_t r;
        r.flag  = 1'b0;
        r.value = v[VAL_W-1:0];
        if (v > SAT_HI)
        begin
            r.flag  = 1'b1;
            r.value = SAT_HI[VAL_W-1:0];
        end
        else if (v < SAT_LO)
        begin
            r.flag  = 1'b1;
            r.value = SAT_LO[VAL_W-1:0];
        end
        return r;
    endfunction

    // effective grid size
    always_comb
    begin
        if (cfg.rows_used < 7'd2)
        begin
            rows_eff = NW'(2);
        end
        else if (32'(cfg.rows_used) > MAX_ROWS)
        begin
            rows_eff = NW'(MAX_ROWS);
        end
        else
        begin
            rows_eff = NW'(cfg.rows_used);
        end
        if (cfg.cols_used < 7'd2)
        begin
            cols_eff = NW'(2);
        end
        else if (32'(cfg.cols_used) > MAX_COLS)
        begin
            cols_eff = NW'(MAX_COLS);
        end
        else
        begin
            cols_eff = NW'(cfg.cols_used);
        end
    end

    assign near  = (cfg.mode == MODE_NEAREST);
    assign cubic = (cfg.mode == MODE_BICUBIC) || (cfg.mode == MODE_CUBIC_ALT);

    assign dx = $signed({query_x[31], query_x}) - $signed({cfg.x_origin[31], cfg.x_origin});
    assign dy = $signed({query_y[31], query_y}) - $signed({cfg.y_origin[31], cfg.y_origin});

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            DP_MX_LO:
            begin
                mul_a = ACC_W'({1'b0, adx_reg});
                mul_b = T_W'({1'b0, cfg.x_scale[15:0]});
            end
            DP_MX_HI:
            begin
                mul_a = ACC_W'({1'b0, adx_reg});
                mul_b = T_W'({1'b0, cfg.x_scale[31:16]});
            end
            DP_MY_LO:
            begin
                mul_a = ACC_W'({1'b0, ady_reg});
                mul_b = T_W'({1'b0, cfg.y_scale[15:0]});
            end
            DP_MY_HI:
            begin
                mul_a = ACC_W'({1'b0, ady_reg});
                mul_b = T_W'({1'b0, cfg.y_scale[31:16]});
            end
            DP_MUL:
            begin
                mul_a = acc_reg;
                mul_b = cmd.t_fy ? fy_reg : fx_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign prod_rnd = (prod_reg + ROUND_Q16) >>> 16;
    assign acc_half = (acc_reg + ACC_W'(1)) >>> 1;
    assign half_sat = sat32(acc_half);
    assign acc_sat  = sat32(acc_reg);

    assign ax_x = axis_map(mx_reg, negx_reg, rows_eff, near);
    assign ax_y = axis_map(my_reg, negy_reg, cols_eff, near);

    // neighbour offsets for the read sequence
    always_comb
    begin
        if (near)
        begin
            off_i = 3'sd0;
            off_j = 3'sd0;
        end
        else if (cubic)
        begin
            off_i = $signed({1'b0, cmd.rd_idx[1:0]}) - 3'sd1;
            off_j = $signed({1'b0, cmd.rd_idx[3:2]}) - 3'sd1;
        end
        else
        begin
            off_i = $signed({2'b00, cmd.rd_idx[0]});
            off_j = $signed({2'b00, cmd.rd_idx[1]});
        end
    end

    assign rd_i     = clamp_idx(i0_reg, off_i, rows_eff);
    assign rd_j     = clamp_idx(j0_reg, off_j, cols_eff);
    assign row_base = rd_i * cols_eff;
    assign rd_addr  = AW'(row_base) + AW'(rd_j);

    always_comb
    begin
        if (cmd.src_row)
        begin
            v0 = ACC_W'(rowv_reg[3]);
            v1 = ACC_W'(rowv_reg[2]);
            v2 = ACC_W'(rowv_reg[1]);
            v3 = ACC_W'(rowv_reg[0]);
        end
        else
        begin
            v0 = ACC_W'(samp_reg[15]);
            v1 = ACC_W'(samp_reg[14]);
            v2 = ACC_W'(samp_reg[13]);
            v3 = ACC_W'(samp_reg[12]);
        end
    end

    // table memory and sample line
    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_WRITE && 32'(entry_index) < DEPTH)
        begin
            grid_mem[AW'(entry_index)] <= entry_value;
        end
        if (cmd.op == DP_READ)
        begin
            samp_reg[0] <= grid_mem[rd_addr];
            for (int k = 1; k < 16; k++)
            begin
                samp_reg[k] <= samp_reg[k-1];
            end
        end
        else if (cmd.op == DP_CR_ROW)
        begin
            for (int k = 4; k < 16; k++)
            begin
                samp_reg[k] <= samp_reg[k-4];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LOAD:
            begin
                negx_reg     <= dx[32];
                negy_reg     <= dy[32];
                adx_reg      <= dx[32] ? 32'(-dx) : dx[31:0];
                ady_reg      <= dy[32] ? 32'(-dy) : dy[31:0];
                sat_flag_reg <= 1'b0;
            end
            DP_MX_LO:
            begin
                prod_reg <= mul_p;
            end
            DP_MX_HI:
            begin
                prod_reg <= mul_p;
                mx_reg   <= 64'(prod_reg[47:0]);
            end
            DP_MY_LO:
            begin
                prod_reg <= mul_p;
                mx_reg   <= mx_reg + {prod_reg[47:0], 16'b0};
            end
            DP_MY_HI:
            begin
                prod_reg <= mul_p;
                my_reg   <= 64'(prod_reg[47:0]);
            end
            DP_MY_ADD:
            begin
                my_reg <= my_reg + {prod_reg[47:0], 16'b0};
            end
            DP_INDEX:
            begin
                i0_reg <= ax_x.idx;
                j0_reg <= ax_y.idx;
                fx_reg <= ax_x.frac;
                fy_reg <= ax_y.frac;
            end
            DP_BL_A:
            begin
                acc_reg <= ACC_W'(samp_reg[2]) - ACC_W'(samp_reg[3]);
                k0_reg  <= ACC_W'(samp_reg[3]);
            end
            DP_BL_B:
            begin
                hold_reg <= acc_reg;
                acc_reg  <= ACC_W'(samp_reg[0]) - ACC_W'(samp_reg[1]);
                k0_reg   <= ACC_W'(samp_reg[1]);
            end
            DP_BL_C:
            begin
                acc_reg <= acc_reg - hold_reg;
                k0_reg  <= hold_reg;
            end
            DP_CR_INIT:
            begin
                acc_reg <= v3 - v0 + 3 * (v1 - v2);
                k0_reg  <= 2 * v0 - 5 * v1 + 4 * v2 - v3;
                k1_reg  <= v2 - v0;
                k2_reg  <= 2 * v1;
            end
            DP_MUL:
            begin
                prod_reg <= mul_p;
            end
            DP_ACC:
            begin
                acc_reg <= $signed(prod_rnd[ACC_W-1:0]) + k0_reg;
                k0_reg  <= k1_reg;
                k1_reg  <= k2_reg;
            end
            DP_CR_ROW:
            begin
                rowv_reg[0]  <= half_sat.value;
                rowv_reg[1]  <= rowv_reg[0];
                rowv_reg[2]  <= rowv_reg[1];
                rowv_reg[3]  <= rowv_reg[2];
                sat_flag_reg <= sat_flag_reg | half_sat.flag;
            end
            DP_FIN:
            begin
                if (near)
                begin
                    result_reg  <= samp_reg[0];
                    sat_out_reg <= 1'b0;
                end
                else if (cubic)
                begin
                    result_reg  <= half_sat.value;
                    sat_out_reg <= sat_flag_reg | half_sat.flag;
                end
                else
                begin
                    result_reg  <= acc_sat.value;
                    sat_out_reg <= acc_sat.flag;
                end
            end
            default:
            begin
            end
        endcase
    end

    // output holding register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.op == DP_FIN)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.out_full = out_valid_reg;
    assign out_valid     = out_valid_reg;
    assign result_value  = result_reg;
    assign saturated     = sat_out_reg;

endmodule

### hw/rtl/grid_table_interpolator_2d_top.sv
// top level of the 2d grid table interpolator
// A table write is taken while in_ready stays high, so writes can stream back to back. A
// query is accepted in the idle state and holds the block until its result reaches the result
// register; the time that takes is set by the single-port table memory, which gives one entry
// per cycle (1, 4 or 16 entries per query), by the one shared multiplier, used in turn for
// every product and rounding step (four coordinate partial products, three bilinear steps, or
// fifteen Horner steps for the bicubic passes), and by a wait while an earlier result is still
// pending and not taken. A finished result waits in its own register, so the next transaction
// is accepted while it is still pending. Configuration writes must be made while no query is in
// flight.
module grid_table_interpolator_2d_top
    import gti_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [11:0]        entry_index,
    input  logic signed [31:0] entry_value,
    input  logic signed [31:0] query_x,
    input  logic signed [31:0] query_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] result_value,
    output logic               saturated
);

`include "grid_table_interpolator_2d_top_defines.svh"

    cfg_t  cfg_reg;
    cmd_t  cmd;
    stat_t stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode      <= MODE_BILINEAR;
            cfg_reg.x_origin  <= '0;
            cfg_reg.y_origin  <= '0;
            cfg_reg.x_scale   <= 32'h0001_0000;
            cfg_reg.y_scale   <= 32'h0001_0000;
            cfg_reg.rows_used <= 7'd64;
            cfg_reg.cols_used <= 7'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:     cfg_reg.mode      <= cfg_data[1:0];
                REG_X_ORIGIN: cfg_reg.x_origin  <= cfg_data;
                REG_Y_ORIGIN: cfg_reg.y_origin  <= cfg_data;
                REG_X_SCALE:  cfg_reg.x_scale   <= cfg_data;
                REG_Y_SCALE:  cfg_reg.y_scale   <= cfg_data;
                REG_ROWS:     cfg_reg.rows_used <= cfg_data[6:0];
                REG_COLS:     cfg_reg.cols_used <= cfg_data[6:0];
                default:
                begin
                end
            endcase
        end
    end

    gti_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .kind      (kind),
        .out_ready (out_ready),
        .mode      (cfg_reg.mode),
        .stat      (stat),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    gti_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg          (cfg_reg),
        .entry_index  (entry_index),
        .entry_value  (entry_value),
        .query_x      (query_x),
        .query_y      (query_y),
        .out_ready    (out_ready),
        .stat         (stat),
        .out_valid    (out_valid),
        .result_value (result_value),
        .saturated    (saturated)
    );

    // a query transaction occupies the block
    `GTI_ASSERT_NEXT(a_query_busy, in_valid && in_ready && kind == KIND_QUERY,
        !in_ready, "query accepted but block still ready")
    // a table write leaves the block free
    `GTI_ASSERT_NEXT(a_write_free, in_valid && in_ready && kind == KIND_WRITE,
        in_ready, "write transaction stalled the block")
    // a new result only follows query work
    `GTI_ASSERT_IMPL(a_result_after_work, $rose(out_valid), $past(!in_ready),
        "result appeared without a query")
    // a waiting result holds still
    `GTI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(result_value) && $stable(saturated),
        "result changed while waiting")

endmodule

### dv/tb_grid_table_interpolator_2d_top.sv
// self-checking testbench for the 2d grid table interpolator
`timescale 1ns / 100ps

module tb_grid_table_interpolator_2d_top
    import gti_pkg::*;
();

    localparam int TBL_ROWS = 64;
    localparam int TBL_COLS = 64;
    localparam int TBL_DEPTH = TBL_ROWS * TBL_COLS;
    localparam longint T_LIM = 64'sd524288;
    localparam longint CYCLE_LIMIT = 64'd1500000;

    typedef struct {
        logic        kind;
        logic [11:0] index;
        logic [31:0] value;
        logic [31:0] qx;
        logic [31:0] qy;
        logic        has_exp;
        logic [31:0] exp_value;
        logic        exp_sat;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [11:0] entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
    logic        out_valid;
    logic        out_ready;
    logic signed [31:0] result_value;
    logic        saturated;

    // predictor state
    logic [1:0]  m_mode;
    longint      m_xorg;
    longint      m_yorg;
    longint      m_xscale;
    longint      m_yscale;
    longint      m_rows;
    longint      m_cols;
    logic [31:0] m_grid [TBL_DEPTH];

    logic [31:0] exp_value_q [$];
    logic        exp_sat_q [$];
    int          errors;
    int          send_idle_pct;
    int          recv_stall_pct;
    longint      cycles;

    grid_table_interpolator_2d_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .entry_index  (entry_index),
        .entry_value  (entry_value),
        .query_x      (query_x),
        .query_y      (query_y),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .saturated    (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint rnd_q16(longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic longint sat_val(longint v, inout bit flag);
        if (v > 64'sd2147483647)
        begin
            flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint grid_at(longint i, longint j);
        longint ii;
        longint jj;
        ii = clampl(i, 0, m_rows - 1);
        jj = clampl(j, 0, m_cols - 1);
        return longint'($signed(m_grid[ii * m_cols + jj]));
    endfunction

    function automatic longint cr_spline(longint t, longint v0, longint v1, longint v2,
                                         longint v3);
        longint acc;
        acc = -v0 + 3 * v1 - 3 * v2 + v3;
        acc = rnd_q16(acc * t) + (2 * v0 - 5 * v1 + 4 * v2 - v3);
        acc = rnd_q16(acc * t) + (v2 - v0);
        acc = rnd_q16(acc * t) + 2 * v1;
        return (acc + 1) >>> 1;
    endfunction

    // magnitude of the q.28 grid coordinate
    function automatic logic [63:0] coord_mag(logic [31:0] q, longint org, longint scale,
                                              output bit neg);
        longint d;
        logic [63:0] ad;
        d = longint'($signed(q)) - org;
        neg = d < 0;
        ad = neg ? 64'(-d) : 64'(d);
        return ad * 64'(scale);
    endfunction

    function automatic longint coord_q16(logic [63:0] m, bit neg);
        if (neg)
            return -longint'((m + 64'd4095) >> 12);
        return longint'(m >> 12);
    endfunction

    function automatic void interpolate(logic [31:0] qx, logic [31:0] qy,
                                        output logic [31:0] res, output logic sat);
        bit nx;
        bit ny;
        bit flag;
        logic [63:0] mx;
        logic [63:0] my;
        longint r;
        longint gx;
        longint gy;
        longint i0;
        longint j0;
        longint fx;
        longint fy;
        longint a;
        longint b;
        longint rowv [4];
        flag = 1'b0;
        mx = coord_mag(qx, m_xorg, m_xscale, nx);
        my = coord_mag(qy, m_yorg, m_yscale, ny);
        if (m_mode == MODE_NEAREST)
        begin
            i0 = nx ? 0 : clampl(longint'((mx + 64'd134217728) >> 28), 0, m_rows - 1);
            j0 = ny ? 0 : clampl(longint'((my + 64'd134217728) >> 28), 0, m_cols - 1);
            r = grid_at(i0, j0);
        end
        else
        begin
            gx = coord_q16(mx, nx);
            gy = coord_q16(my, ny);
            i0 = gx < 0 ? 0 : clampl(gx >>> 16, 0, m_rows - 2);
            j0 = gy < 0 ? 0 : clampl(gy >>> 16, 0, m_cols - 2);
            fx = clampl(gx - i0 * 65536, -T_LIM, T_LIM);
            fy = clampl(gy - j0 * 65536, -T_LIM, T_LIM);
            if (m_mode == MODE_BILINEAR)
            begin
                a = grid_at(i0, j0) + rnd_q16(fx * (grid_at(i0 + 1, j0) - grid_at(i0, j0)));
                b = grid_at(i0, j0 + 1)
                    + rnd_q16(fx * (grid_at(i0 + 1, j0 + 1) - grid_at(i0, j0 + 1)));
                r = sat_val(a + rnd_q16(fy * (b - a)), flag);
            end
            else
            begin
                for (int k = 0; k < 4; k++)
                    rowv[k] = sat_val(cr_spline(fx, grid_at(i0 - 1, j0 - 1 + k),
                                      grid_at(i0, j0 - 1 + k), grid_at(i0 + 1, j0 - 1 + k),
                                      grid_at(i0 + 2, j0 - 1 + k)), flag);
                r = sat_val(cr_spline(fy, rowv[0], rowv[1], rowv[2], rowv[3]), flag);
            end
        end
        res = r[31:0];
        sat = flag;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_MODE:     m_mode = data[1:0];
            REG_X_ORIGIN: m_xorg = longint'($signed(data));
            REG_Y_ORIGIN: m_yorg = longint'($signed(data));
            REG_X_SCALE:  m_xscale = longint'(data);
            REG_Y_SCALE:  m_yscale = longint'(data);
            REG_ROWS:     m_rows = clampl(longint'(data[6:0]), 2, TBL_ROWS);
            REG_COLS:     m_cols = clampl(longint'(data[6:0]), 2, TBL_COLS);
            default: ;
        endcase
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (exp_value_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // one transaction; typed expectation overrides the predictor when given
    task automatic send_item(stim_row_t s);
        logic [31:0] pv;
        logic        ps;
        int          idle;
        idle = 0;
        while ($urandom_range(99) < send_idle_pct)
            idle++;
        if (idle != 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= s.kind;
        entry_index <= s.index;
        entry_value <= s.value;
        query_x <= s.qx;
        query_y <= s.qy;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (s.kind == KIND_WRITE)
        begin
            if (s.index < TBL_DEPTH)
                m_grid[s.index] = s.value;
        end
        else
        begin
            interpolate(s.qx, s.qy, pv, ps);
            if (s.has_exp)
            begin
                pv = s.exp_value;
                ps = s.exp_sat;
            end
            exp_value_q = {exp_value_q, pv};
            exp_sat_q = {exp_sat_q, ps};
        end
    endtask

    function automatic stim_row_t wr_row(int idx, logic [31:0] v);
        stim_row_t s;
        s = '{KIND_WRITE, idx[11:0], v, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0};
        return s;
    endfunction

    function automatic stim_row_t q_row(logic [31:0] x, logic [31:0] y);
        stim_row_t s;
        s = '{KIND_QUERY, 12'd0, 32'd0, x, y, 1'b0, 32'd0, 1'b0};
        return s;
    endfunction

    function automatic stim_row_t qe_row(logic [31:0] x, logic [31:0] y, logic [31:0] ev,
                                         logic es);
        stim_row_t s;
        s = '{KIND_QUERY, 12'd0, 32'd0, x, y, 1'b1, ev, es};
        return s;
    endfunction

    function automatic logic [31:0] rnd_value();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return 32'($signed($urandom_range(2000000)) - 1000000);
        endcase
    endfunction

    // coordinate near or inside the grid, sometimes wild
    function automatic logic [31:0] rnd_coord(longint n);
        if ($urandom_range(9) == 0)
            return $urandom();
        return 32'($signed($urandom_range(32'(n * 4096 + 24576))) - 12288);
    endfunction

    // fill the used region so queries never read unwritten entries
    task automatic fill_table(bit wild);
        for (int k = 0; k < m_rows * m_cols; k++)
            send_item(wr_row(k, wild ? rnd_value() : 32'($signed($urandom_range(80000)) - 40000)));
    endtask

    stim_row_t directed [$];

    function automatic void add_row(stim_row_t r);
        directed = {directed, r};
    endfunction

    initial
    begin
        int cfg_set;
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_MODE;
        cfg_data = '0;
        in_valid = 1'b0;
        kind = KIND_WRITE;
        entry_index = '0;
        entry_value = '0;
        query_x = '0;
        query_y = '0;
        m_mode = MODE_BILINEAR;
        m_xorg = 0;
        m_yorg = 0;
        m_xscale = 65536;
        m_yscale = 65536;
        m_rows = TBL_ROWS;
        m_cols = TBL_COLS;
        for (int k = 0; k < TBL_DEPTH; k++)
            m_grid[k] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: small 3x3 grid, corner writes and extremes
        write_reg(REG_ROWS, 32'd3);
        write_reg(REG_COLS, 32'd3);
        add_row(wr_row(0, 32'h0000_1000));
        add_row(wr_row(1, 32'h7fff_ffff));
        add_row(wr_row(2, 32'h8000_0000));
        add_row(wr_row(3, 32'hffff_f000));
        add_row(wr_row(4, 32'h0000_2000));
        add_row(wr_row(5, 32'h7fff_ffff));
        add_row(wr_row(6, 32'h8000_0000));
        add_row(wr_row(7, 32'h0000_3000));
        add_row(wr_row(8, 32'h0000_0000));
        add_row(wr_row(4095, 32'hdead_beef));
        add_row(qe_row(32'd0, 32'd0, 32'h0000_1000, 1'b0));
        add_row(qe_row(32'h0000_1000, 32'd0, 32'hffff_f000, 1'b0));
        add_row(qe_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1));
        add_row(q_row(32'h7fff_ffff, 32'h7fff_ffff));
        add_row(q_row(32'h0000_0800, 32'h0000_1800));
        add_row(q_row(32'hffff_f800, 32'h0000_2800));
        foreach (directed[n])
            send_item(directed[n]);
        drain();
        write_reg(REG_MODE, {30'd0, MODE_NEAREST});
        send_item(qe_row(32'h0000_0800, 32'd0, 32'hffff_f000, 1'b0));
        send_item(qe_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0000, 1'b0));
        send_item(qe_row(32'h0000_07ff, 32'h0000_0800, 32'h7fff_ffff, 1'b0));
        drain();
        write_reg(REG_MODE, {30'd0, MODE_BICUBIC});
        send_item(q_row(32'h0000_0800, 32'h0000_0800));
        send_item(q_row(32'h7fff_ffff, 32'h8000_0000));
        drain();
        write_reg(REG_MODE, {30'd0, MODE_CUBIC_ALT});
        write_reg(REG_X_SCALE, 32'd0);
        write_reg(REG_Y_SCALE, 32'hffff_ffff);
        send_item(q_row(32'h1234_5678, 32'h0000_0003));
        drain();

        // random phases over several settings
        for (cfg_set = 0; cfg_set < 8; cfg_set++)
        begin
            case (cfg_set % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            write_reg(REG_MODE, 32'($urandom_range(3)));
            write_reg(REG_X_ORIGIN, cfg_set == 7 ? 32'h8000_0000 :
                      32'($signed($urandom_range(8192)) - 4096));
            write_reg(REG_Y_ORIGIN, cfg_set == 6 ? 32'h7fff_ffff :
                      32'($signed($urandom_range(8192)) - 4096));
            write_reg(REG_X_SCALE, cfg_set == 5 ? 32'hffff_ffff :
                      32'($urandom_range(131072, 16384)));
            write_reg(REG_Y_SCALE, cfg_set == 4 ? 32'd0 : 32'($urandom_range(131072, 16384)));
            write_reg(REG_ROWS, cfg_set == 1 ? 32'd64 :
                      ((cfg_set == 2 || cfg_set == 3) ? 32'd2 : 32'($urandom_range(8, 2))));
            write_reg(REG_COLS, cfg_set == 3 ? 32'd64 :
                      (cfg_set == 2 ? 32'd127 :
                      (cfg_set == 1 ? 32'd2 : 32'($urandom_range(8, 2)))));
            fill_table(cfg_set[0]);
            for (int n = 0; n < 70; n++)
            begin
                if ($urandom_range(4) == 0)
                    send_item(wr_row($urandom_range(m_rows * m_cols - 1), rnd_value()));
                else if ($urandom_range(19) == 0)
                    send_item(wr_row($urandom_range(4095, TBL_DEPTH), rnd_value()));
                else
                    send_item(q_row(rnd_coord(m_rows), rnd_coord(m_cols)));
                if (n == 35)
                    drain();
            end
            drain();
        end
        send_idle_pct = 0;
        drain();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (exp_value_q.size() == 0)
                begin
                    $error("unexpected transaction: result_value %h", result_value);
                    errors++;
                end
                else
                begin
                    if (result_value !== exp_value_q[0])
                    begin
                        $error("result_value expected %h actual %h", exp_value_q[0],
                               result_value);
                        errors++;
                    end
                    if (saturated !== exp_sat_q[0])
                    begin
                        $error("saturated expected %b actual %b", exp_sat_q[0], saturated);
                        errors++;
                    end
                    void'(exp_value_q.pop_front());
                    void'(exp_sat_q.pop_front());
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/gti_pkg.sv
hw/rtl/gti_ctrl.sv
hw/rtl/gti_datapath.sv
hw/rtl/grid_table_interpolator_2d_top.sv
dv/tb_grid_table_interpolator_2d_top.sv
